// ----- rtl/core/ska_pkg.sv -----
package ska_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned ECOUNT_W = 6;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } ska_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } ska_status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;  // capture the compare flags against the command key
    logic ins;  // open a gap at the boundary and drop the key in
    logic rem;  // close the gap at the boundary
  } ska_ctl_t;

endpackage

// ----- rtl/core/ska_cell.sv -----
module ska_cell
  import ska_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 6
) (
  input  logic             clk,
  input  ska_ctl_t         ctl,
  input  logic [KEY_W-1:0] cmd_key,
  input  logic [POS_W-1:0] cmd_pos,
  input  logic [CNT_W-1:0] count,
  input  logic [KEY_W-1:0] left_key,
  input  logic [KEY_W-1:0] right_key,
  input  logic             left_lt,
  output logic [KEY_W-1:0] key,
  output logic             lt,
  output logic             eq,
  output logic             rd_sel,
  output logic             bnd
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);
  localparam bit               IDX_READABLE = (INDEX < (1 << POS_W));

  logic occupied;

  assign occupied = (count > IDX_C);
  // The boundary cell is the first one whose key is not below the command key.
  assign bnd = !lt && left_lt;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt     <= occupied && (key < cmd_key);
      eq     <= occupied && (key == cmd_key);
      rd_sel <= occupied && IDX_READABLE && (cmd_pos == POS_W'(INDEX));
    end
    if (ctl.ins && !lt) begin
      key <= left_lt ? cmd_key : left_key;
    end else if (ctl.rem && !lt) begin
      key <= right_key;
    end
  end

endmodule

// ----- rtl/core/sorted_key_table_core.sv -----
// Sorted table of unique 32-bit keys held in a chain of CAPACITY cells, one key
// per cell, in ascending order from cell 0. Each item goes through these steps:
// the transaction is taken, all cells compare their key against the item's key in
// parallel, and then the boundary position is encoded while each cell at or
// above it loads its left (insert) or right (remove) neighbor in one shift. The
// result goes to an output register, so the next item is taken while a result
// still waits; no new item is taken before the last one has executed. An insert
// of a new key into a full table reports status full and changes nothing.
// Read-at reaches positions 0 to 31 only, as the position field is 5 bits.
module sorted_key_table_core
  import ska_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // key[31:0], position[36:32], zero[39:37]
  input  logic [1:0]  s_tuser,  // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // slot[4:0], key_out[36:5], entry_count[42:37], zero[47:43]
  output logic [1:0]  m_tuser   // status[1:0]
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t             state;
  ska_op_t            op;
  logic [KEY_W-1:0]   cmd_key;
  logic [POS_W-1:0]   cmd_pos;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  logic [KEY_W-1:0]   keys   [CAPACITY];
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] eq_v;
  logic [CAPACITY-1:0] rd_v;
  logic [CAPACITY-1:0] bnd_v;

  ska_ctl_t           ctl;
  logic               exec_go;
  logic               hit;
  logic               full;
  logic [IDX_W-1:0]   p_enc;
  logic [CNT_W-1:0]   p;
  logic [KEY_W-1:0]   rd_key;
  ska_status_t        status_next;
  logic [CNT_W-1:0]   slot_next;
  logic [KEY_W-1:0]   key_out_next;
  logic [31:0]        slot_ext;
  logic [31:0]        cnt_ext;

  assign s_tready = (state == S_IDLE);
  assign exec_go  = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign hit      = |eq_v;
  assign full     = (count == CAP_C);

  always_comb begin
    ctl.cmp = (state == S_CMP);
    ctl.ins = exec_go && (op == OP_INSERT) && !hit && !full;
    ctl.rem = exec_go && (op == OP_REMOVE) && hit;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ska_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cmd_key   (cmd_key),
      .cmd_pos   (cmd_pos),
      .count     (count),
      .left_key  ((i == 0) ? cmd_key : keys[(i == 0) ? 0 : i - 1]),
      .right_key ((i == CAPACITY - 1) ? keys[i] : keys[(i == CAPACITY - 1) ? i : i + 1]),
      .left_lt   ((i == 0) ? 1'b1 : lt_v[(i == 0) ? 0 : i - 1]),
      .key       (keys[i]),
      .lt        (lt_v[i]),
      .eq        (eq_v[i]),
      .rd_sel    (rd_v[i]),
      .bnd       (bnd_v[i])
    );
  end

  // Boundary and read selects are one-hot or zero, so OR trees act as the encoders.
  always_comb begin
    p_enc  = '0;
    rd_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      p_enc  = p_enc | (bnd_v[i] ? IDX_W'(i) : '0);
      rd_key = rd_key | (rd_v[i] ? keys[i] : '0);
    end
    p = lt_v[CAPACITY-1] ? count : CNT_W'(p_enc);
  end

  always_comb begin
    status_next  = ST_OK;
    slot_next    = p;
    key_out_next = cmd_key;
    count_next   = count;
    unique case (op)
      OP_INSERT: begin
        if (!hit && full) begin
          status_next  = ST_FULL;
          slot_next    = '0;
          key_out_next = '0;
        end else if (!hit) begin
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          count_next = count - 1'b1;
        end else begin
          status_next  = ST_MISS;
          slot_next    = '0;
          key_out_next = '0;
        end
      end
      OP_LOOKUP: begin
        if (!hit) begin
          status_next  = ST_MISS;
          slot_next    = '0;
          key_out_next = '0;
        end
      end
      OP_READ: begin
        if (|rd_v) begin
          slot_next    = CNT_W'(cmd_pos);
          key_out_next = rd_key;
        end else begin
          status_next  = ST_MISS;
          slot_next    = '0;
          key_out_next = '0;
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
    slot_ext = 32'(slot_next);
    cnt_ext  = 32'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is loaded keeps valid high.
      if (m_tvalid && m_tready && !exec_go) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= ska_op_t'(s_tuser);
            cmd_key <= s_tdata[31:0];
            cmd_pos <= s_tdata[36:32];
            state   <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            count    <= count_next;
            m_tvalid <= 1'b1;
            m_tuser  <= status_next;
            m_tdata  <= {5'd0, cnt_ext[ECOUNT_W-1:0], key_out_next, slot_ext[SLOT_W-1:0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count beyond capacity");

  a_single_bnd: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(bnd_v))
    else $error("more than one boundary cell in the chain");

  a_unique_key: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(eq_v))
    else $error("key held in more than one cell");

  a_hit_at_bnd: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && hit |-> ((eq_v & bnd_v) == eq_v))
    else $error("matching cell is not the boundary cell");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !exec_go |=> $stable(count))
    else $error("entry count changed outside an execute cycle");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> m_tvalid)
    else $error("executed item produced no result");

endmodule

// ----- dv/sorted_key_table_core_tb.sv -----
module sorted_key_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ska_pkg::*;

  localparam int unsigned CAPACITY   = 32;
  localparam int unsigned N_RANDOM   = 1300;
  localparam int unsigned POOL_SIZE  = 40;
  localparam int unsigned CYCLE_CAP  = 300000;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct {
    ska_op_t           op;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos;
  } key_cmd_t;

  typedef struct {
    ska_status_t          status;
    logic [SLOT_W-1:0]    slot;
    logic [KEY_W-1:0]     key_out;
    logic [ECOUNT_W-1:0]  entry_count;
  } key_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // key[31:0], position[36:32], zero[39:37]
  logic [1:0]  s_tuser = '0;  // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;       // slot[4:0], key_out[36:5], entry_count[42:37], zero[47:43]
  logic [1:0]  m_tuser;       // status[1:0]

  sorted_key_table_core #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Shadow of the sorted keys and their count.
  logic [KEY_W-1:0] sorted_keys [CAPACITY];
  int unsigned      key_count = 0;

  key_cmd_t   pending_cmds [$];
  key_reply_t table_replies [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int unsigned mismatches      = 0;
  int unsigned replies_checked = 0;
  int unsigned cycle_count     = 0;

  function automatic key_reply_t apply_key_op(ska_op_t op, logic [KEY_W-1:0] k,
                                              logic [POS_W-1:0] pos);
    key_reply_t  r;
    int unsigned lb;
    bit          hit;
    lb = 0;
    while (lb < key_count && sorted_keys[lb] < k) lb++;
    hit = (lb < key_count) && (sorted_keys[lb] == k);
    r.status  = ST_MISS;
    r.slot    = '0;
    r.key_out = '0;
    case (op)
      OP_INSERT: begin
        if (hit) begin
          r.status = ST_OK;
          r.slot = lb[SLOT_W-1:0];
          r.key_out = k;
        end else if (key_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int j = key_count; j > lb; j--) sorted_keys[j] = sorted_keys[j-1];
          sorted_keys[lb] = k;
          key_count++;
          r.status = ST_OK;
          r.slot = lb[SLOT_W-1:0];
          r.key_out = k;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          for (int j = lb + 1; j < key_count; j++) sorted_keys[j-1] = sorted_keys[j];
          key_count--;
          r.status = ST_OK;
          r.slot = lb[SLOT_W-1:0];
          r.key_out = k;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          r.status = ST_OK;
          r.slot = lb[SLOT_W-1:0];
          r.key_out = k;
        end
      end
      default: begin
        if (pos < key_count) begin
          r.status = ST_OK;
          r.slot = pos;
          r.key_out = sorted_keys[pos];
        end
      end
    endcase
    r.entry_count = key_count[ECOUNT_W-1:0];
    return r;
  endfunction

  function automatic void push_cmd(ska_op_t op, logic [KEY_W-1:0] k, logic [POS_W-1:0] pos);
    key_cmd_t c;
    c.op = op;
    c.key = k;
    c.pos = pos;
    pending_cmds.push_back(c);
  endfunction

  function automatic void report_field(string name, logic [KEY_W-1:0] want,
                                       logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_proc
    key_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        table_replies.push_back(apply_key_op(ska_op_t'(s_tuser), s_tdata[31:0],
                                             s_tdata[36:32]));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || pending_cmds.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          c = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= c.op;
          s_tdata  <= {3'b000, c.pos, c.key};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Receiver: a stall pattern redrawn at random by stall_cycle, plus long hold-offs
  // that let the core back up into its input.
  int unsigned hold_left    = 0;
  int unsigned holds_done   = 0;
  int unsigned next_hold_at = 300;
  int unsigned stall_cycle  = 0;
  int unsigned stall_mode   = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_done < 2 && replies_checked >= next_hold_at) begin
        hold_left = HOLD_LEN;
        holds_done++;
        next_hold_at += 500;
        m_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (stall_cycle % 4 == 0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_proc
    key_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (table_replies.size() == 0) begin
        $display("%0t: result with none pending, got status %0h data %0h",
                 $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = table_replies.pop_front();
        report_field("status", want.status, m_tuser);
        report_field("slot", want.slot, m_tdata[4:0]);
        report_field("key_out", want.key_out, m_tdata[36:5]);
        report_field("entry_count", want.entry_count, m_tdata[42:37]);
        replies_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_left;
    bit          filling;
    int unsigned pick;
    ska_op_t     op;
    logic [KEY_W-1:0] k;
    logic [POS_W-1:0] pos;

    // Pool with the extremes and a run of neighbors so ordering edges get hit.
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFE;
    key_pool[3] = 32'h0000_0001;
    k = $urandom;
    for (int i = 4; i < 10; i++) key_pool[i] = k + (i - 4);
    for (int i = 10; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed: empty-table misses, extremes, duplicates, edge positions, removal
    // at the front, middle and back.
    push_cmd(OP_READ,   32'h0,         5'd0);
    push_cmd(OP_LOOKUP, 32'h0,         5'd0);
    push_cmd(OP_REMOVE, 32'h5,         5'd0);
    push_cmd(OP_INSERT, 32'h8000_0000, 5'd31);
    push_cmd(OP_INSERT, 32'h0,         5'd0);
    push_cmd(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
    push_cmd(OP_INSERT, 32'h8000_0000, 5'd0);
    push_cmd(OP_INSERT, 32'h1,         5'd0);
    push_cmd(OP_INSERT, 32'hFFFF_FFFE, 5'd0);
    push_cmd(OP_LOOKUP, 32'h0,         5'd0);
    push_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 5'd0);
    push_cmd(OP_LOOKUP, 32'h2,         5'd0);
    push_cmd(OP_READ,   32'hFFFF_FFFF, 5'd0);
    push_cmd(OP_READ,   32'h0,         5'd4);
    push_cmd(OP_READ,   32'h0,         5'd5);
    push_cmd(OP_READ,   32'h0,         5'd31);
    push_cmd(OP_REMOVE, 32'h8000_0000, 5'd0);
    push_cmd(OP_REMOVE, 32'h0,         5'd0);
    push_cmd(OP_REMOVE, 32'hFFFF_FFFF, 5'd0);
    push_cmd(OP_REMOVE, 32'hFFFF_FFFF, 5'd0);
    push_cmd(OP_REMOVE, 32'h1,         5'd0);
    push_cmd(OP_REMOVE, 32'hFFFF_FFFE, 5'd0);
    push_cmd(OP_READ,   32'h0,         5'd0);

    // Random: alternate insert-heavy and remove-heavy phases over a key pool a
    // little larger than the table, so it fills, overflows and drains often.
    phase_left = 0;
    filling = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 120);
        filling = !filling;
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (filling)
        op = (pick < 65) ? OP_INSERT : (pick < 75) ? OP_REMOVE :
             (pick < 90) ? OP_LOOKUP : OP_READ;
      else
        op = (pick < 15) ? OP_INSERT : (pick < 70) ? OP_REMOVE :
             (pick < 85) ? OP_LOOKUP : OP_READ;
      k = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      pos = ($urandom_range(0, 7) == 0) ? 5'd31 : 5'($urandom_range(0, 31));
      push_cmd(op, k, pos);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || s_tvalid) @(posedge clk);
    while (table_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && table_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ska_pkg.sv
rtl/core/ska_cell.sv
rtl/core/sorted_key_table_core.sv
dv/sorted_key_table_core_tb.sv
